// ===== rtl/core/obwb_pkg.sv =====
// ----------------------------------------------------------------------------
// obwb_pkg
// Shared types, register indexes and fixed-point helpers for the oriented
// box world bounds block.
// ----------------------------------------------------------------------------
package obwb_pkg;

  // coordinate Q15.16, quaternion component Q1.30, both 32-bit signed
  typedef logic signed [31:0] coord_t;
  typedef coord_t [2:0] vec3_t;

  typedef struct packed {
    coord_t w;
    vec3_t  v;
  } quat_t;

  // shifted product and the widest intermediate sum
  localparam int PROD_W = 34;
  localparam int WIDE_W = 37;
  localparam int QUAT_FRAC = 30;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam int NUM_CORNERS = 8;

  localparam wide_t SAT_MAX = wide_t'(32'sh7FFF_FFFF);
  localparam wide_t SAT_MIN = wide_t'(-33'sh0_8000_0000);

  // exact product, then arithmetic shift right by the quaternion fraction
  function automatic prod_t qmul(input coord_t q, input coord_t c);
    logic signed [63:0] p;
    p = 64'(q) * 64'(c);
    return p[63:QUAT_FRAC];
  endfunction

  // clamp to the signed 32-bit range
  function automatic coord_t sat32(input wide_t x);
    coord_t r;
    if (x > SAT_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/obwb_corner.sv =====
// ----------------------------------------------------------------------------
// obwb_corner
// One box corner: rotate by the quaternion (two cross products and the
// w term) and add the position, six register stages after the input stage.
// ----------------------------------------------------------------------------
module obwb_corner (
  input  logic           clk,
  input  obwb_pkg::vec3_t corner,
  input  obwb_pkg::quat_t q0,
  input  obwb_pkg::quat_t q2,
  input  obwb_pkg::vec3_t pos5,
  output obwb_pkg::vec3_t wc6
);

  obwb_pkg::prod_t p1_a [3];
  obwb_pkg::prod_t p1_b [3];
  obwb_pkg::vec3_t uv2;
  obwb_pkg::prod_t p3_a [3];
  obwb_pkg::prod_t p3_b [3];
  obwb_pkg::prod_t wuv3 [3];
  obwb_pkg::vec3_t uuv4;
  obwb_pkg::prod_t wuv4 [3];
  obwb_pkg::vec3_t rot5;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    localparam int B = (a + 1) % 3;
    localparam int C = (a + 2) % 3;

    // first cross product terms, q x v
    always_ff @(posedge clk) begin
      p1_a[a] <= obwb_pkg::qmul(q0.v[B], corner[C]);
      p1_b[a] <= obwb_pkg::qmul(q0.v[C], corner[B]);
    end

    // uv difference and clamp
    always_ff @(posedge clk) begin
      uv2[a] <= obwb_pkg::sat32(obwb_pkg::wide_t'($signed(p1_a[a]))
                               - obwb_pkg::wide_t'($signed(p1_b[a])));
    end

    // second cross product terms, q x uv, and the w term
    always_ff @(posedge clk) begin
      p3_a[a] <= obwb_pkg::qmul(q2.v[B], uv2[C]);
      p3_b[a] <= obwb_pkg::qmul(q2.v[C], uv2[B]);
      wuv3[a] <= obwb_pkg::qmul(q2.w, uv2[a]);
    end

    // uuv difference and clamp
    always_ff @(posedge clk) begin
      uuv4[a] <= obwb_pkg::sat32(obwb_pkg::wide_t'($signed(p3_a[a]))
                                - obwb_pkg::wide_t'($signed(p3_b[a])));
      wuv4[a] <= wuv3[a];
    end

    // rotated corner v + 2 * (w*uv + uuv)
    always_ff @(posedge clk) begin
      rot5[a] <= obwb_pkg::sat32(obwb_pkg::wide_t'($signed(corner[a]))
                 + ((obwb_pkg::wide_t'($signed(wuv4[a]))
                   + obwb_pkg::wide_t'($signed(uuv4[a]))) <<< 1));
    end

    // translate into world space
    always_ff @(posedge clk) begin
      wc6[a] <= obwb_pkg::sat32(obwb_pkg::wide_t'($signed(rot5[a]))
                               + obwb_pkg::wide_t'($signed(pos5[a])));
    end
  end

endmodule

// ===== rtl/core/oriented_box_world_bounds.sv =====
// Result: a pose accepted on start passes the input stage, the corner pipelines
// and the min/max tree, and its bounds beat shows on done for one cycle.
// Throughput: one pose per cycle; busy stays low, set by the eight parallel
// corner pipelines, each with one multiplier stage per product.
// Reset: synchronous, clears the box registers to zero and the valid pipe.
// The receiver cannot stall; every result appears exactly once.
// ----------------------------------------------------------------------------
// oriented_box_world_bounds
// Axis-aligned world bounds of a local box placed by a position and a
// quaternion: eight corner pipelines and a registered min/max tree.
// ----------------------------------------------------------------------------
module oriented_box_world_bounds (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  output logic                                done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [obwb_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic signed [31:0]                  pos_x,
  input  logic signed [31:0]                  pos_y,
  input  logic signed [31:0]                  pos_z,
  input  logic signed [31:0]                  quat_w,
  input  logic signed [31:0]                  quat_x,
  input  logic signed [31:0]                  quat_y,
  input  logic signed [31:0]                  quat_z,
  output logic signed [31:0]                  world_min_x,
  output logic signed [31:0]                  world_min_y,
  output logic signed [31:0]                  world_min_z,
  output logic signed [31:0]                  world_max_x,
  output logic signed [31:0]                  world_max_y,
  output logic signed [31:0]                  world_max_z
);

  localparam int NUM_STAGES = 10;

  logic                  accept;
  logic [NUM_STAGES-1:0] vld;
  obwb_pkg::vec3_t       box_min;
  obwb_pkg::vec3_t       box_max;
  obwb_pkg::quat_t       q0;
  obwb_pkg::quat_t       q1;
  obwb_pkg::quat_t       q2;
  obwb_pkg::vec3_t       pos_pipe [6];
  obwb_pkg::vec3_t       wc6 [obwb_pkg::NUM_CORNERS];
  obwb_pkg::vec3_t       lo7 [4];
  obwb_pkg::vec3_t       hi7 [4];
  obwb_pkg::vec3_t       lo8 [2];
  obwb_pkg::vec3_t       hi8 [2];
  obwb_pkg::vec3_t       lo9;
  obwb_pkg::vec3_t       hi9;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // box registers, out-of-range writes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      box_min <= '0;
      box_max <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        obwb_pkg::REG_BOX_MIN_X: box_min[0] <= cfg_data;
        obwb_pkg::REG_BOX_MIN_Y: box_min[1] <= cfg_data;
        obwb_pkg::REG_BOX_MIN_Z: box_min[2] <= cfg_data;
        obwb_pkg::REG_BOX_MAX_X: box_max[0] <= cfg_data;
        obwb_pkg::REG_BOX_MAX_Y: box_max[1] <= cfg_data;
        obwb_pkg::REG_BOX_MAX_Z: box_max[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NUM_STAGES-2:0], accept};
    end
  end

  assign done = vld[NUM_STAGES-1];

  // input stage and the shared quaternion / position delay lines
  always_ff @(posedge clk) begin
    q0.w        <= quat_w;
    q0.v        <= {quat_z, quat_y, quat_x};
    q1          <= q0;
    q2          <= q1;
    pos_pipe[0] <= {pos_z, pos_y, pos_x};
    for (int i = 1; i < 6; i++) begin
      pos_pipe[i] <= pos_pipe[i-1];
    end
  end

  // eight corner lanes; corner bit 2 picks x, bit 1 y, bit 0 z
  for (genvar c = 0; c < obwb_pkg::NUM_CORNERS; c++) begin : g_corner
    localparam logic [2:0] SEL = 3'(c);
    obwb_pkg::vec3_t corner;

    assign corner[0] = SEL[2] ? box_max[0] : box_min[0];
    assign corner[1] = SEL[1] ? box_max[1] : box_min[1];
    assign corner[2] = SEL[0] ? box_max[2] : box_min[2];

    obwb_corner u_corner (
      .clk    (clk),
      .corner (corner),
      .q0     (q0),
      .q2     (q2),
      .pos5   (pos_pipe[5]),
      .wc6    (wc6[c])
    );
  end

  // min/max tree, first level over corner pairs
  for (genvar k = 0; k < 4; k++) begin : g_lvl1
    for (genvar a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clk) begin
        lo7[k][a] <= ($signed(wc6[2*k][a]) < $signed(wc6[2*k+1][a])) ?
                     wc6[2*k][a] : wc6[2*k+1][a];
        hi7[k][a] <= ($signed(wc6[2*k][a]) > $signed(wc6[2*k+1][a])) ?
                     wc6[2*k][a] : wc6[2*k+1][a];
      end
    end
  end

  // second level
  for (genvar k = 0; k < 2; k++) begin : g_lvl2
    for (genvar a = 0; a < 3; a++) begin : g_axis
      always_ff @(posedge clk) begin
        lo8[k][a] <= ($signed(lo7[2*k][a]) < $signed(lo7[2*k+1][a])) ?
                     lo7[2*k][a] : lo7[2*k+1][a];
        hi8[k][a] <= ($signed(hi7[2*k][a]) > $signed(hi7[2*k+1][a])) ?
                     hi7[2*k][a] : hi7[2*k+1][a];
      end
    end
  end

  // output register
  for (genvar a = 0; a < 3; a++) begin : g_out
    always_ff @(posedge clk) begin
      lo9[a] <= ($signed(lo8[0][a]) < $signed(lo8[1][a])) ? lo8[0][a] : lo8[1][a];
      hi9[a] <= ($signed(hi8[0][a]) > $signed(hi8[1][a])) ? hi8[0][a] : hi8[1][a];
    end
  end

  assign world_min_x = lo9[0];
  assign world_min_y = lo9[1];
  assign world_min_z = lo9[2];
  assign world_max_x = hi9[0];
  assign world_max_y = hi9[1];
  assign world_max_z = hi9[2];

`ifndef ASSERT_OFF
  // every result beat traces back to an accepted pose
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, NUM_STAGES))
    else $error("result beat without an accepted pose");

  // bounds are ordered on every axis
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    done |-> (world_min_x <= world_max_x) && (world_min_y <= world_max_y)
             && (world_min_z <= world_max_z))
    else $error("world min exceeds world max");

  // the configuration port never stalls and the block never reports busy
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_ready && !busy)
    else $error("unexpected stall on a port");
`endif

endmodule
